>>> hdl/scm_pkg.sv
`default_nettype none
package scm_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 64;
  localparam int unsigned CNT_W = 7;
  localparam int unsigned IN_TDATA_W = 128;
  localparam int unsigned OUT_TDATA_W = 112;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PASS,
    ST_DIVM,
    ST_DIVS,
    ST_MULM,
    ST_VAR,
    ST_CONV,
    ST_DEC,
    ST_EMIT
  } state_e;

endpackage
`default_nettype wire

>>> hdl/sigma_clip_mean_variance.sv
`default_nettype none
// Loading: one sample per cycle. On the last sample, one or two clip passes run over the
// sample memory; when any sample is kept, each pass is followed by two serial divisions and
// the squaring of the mean, then by the variance, convergence and decision states. Results
// leave one at a time (memory read, output register, handshake).
// Reset: asynchronous, clears the sample count and all control; sample memory is not cleared.
module sigma_clip_mean_variance
  import scm_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // sample[31:0], start_mean[63:32], start_variance[127:64]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // excluded_in
  input  wire logic                   s_axis_tuser,
  input  wire logic                   s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // sample_index[5:0], clipped_mean[37:6], clipped_variance[101:38], kept_count[108:102]
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  // excluded_out
  output logic                        m_axis_tuser,
  output logic                        m_axis_tlast
);

  localparam int unsigned AW = $clog2(MAX_SAMPLES);
  localparam int unsigned NW = $clog2(MAX_SAMPLES + 1);

  state_e state_q, state_d;

  logic [32:0]   mem [MAX_SAMPLES];
  logic [32:0]   rdata_q;
  logic [AW-1:0] wr_addr;
  logic [32:0]   wr_data;
  logic          wr_en;

  logic [NW-1:0] n_q, idx_q, cnt_q;
  logic          pass2_q;
  logic signed [31:0] hmean_q;
  logic [63:0]   hvar_q;
  logic [67:0]   nine_q;
  logic signed [39:0] sum_q;
  logic [63:0]   sq_q;

  logic          p1_q, p2_q, p3_q;
  logic [AW-1:0] a1_q, a2_q, a3_q;
  logic [31:0]   ad_q, as_q, smp2_q, smp3_q;
  logic          mk2_q, mk3_q;
  logic [63:0]   sqd_q, sqs_q;

  logic [31:0]   mag_q;
  logic          neg_q;
  logic [63:0]   e2_q, m2_q, nv_q, diff_q;
  logic signed [31:0] nm_q;

  logic          pend_q;
  logic [AW-1:0] ea_q;
  logic          out_v_q;
  logic [5:0]    o_idx_q;
  logic          o_excl_q, o_last_q;
  logic [31:0]   o_mean_q;
  logic [63:0]   o_var_q;
  logic [6:0]    o_kept_q;

  logic          in_acc, out_acc, pass_issue, emit_issue, pass_end, emit_end;
  logic          enter_pass, div_start, div_done, again, hit, mark3;
  logic [63:0]   dividend, quot;
  logic [39:0]   abs_sum;
  logic [32:0]   dev;
  logic [31:0]   smp1;
  logic [67:0]   diff10;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = out_v_q && m_axis_tready;

  // ---------------- control ----------------
  assign pass_end = (idx_q == n_q) && !p1_q && !p2_q && !p3_q;
  assign emit_end = (idx_q == n_q) && !pend_q && !out_v_q;
  assign diff10   = {1'b0, diff_q, 3'b000} + {3'b000, diff_q, 1'b0};
  assign again    = diff10 > {4'b0000, nv_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: if (in_acc && s_axis_tlast) state_d = ST_PASS;
      ST_PASS: if (pass_end) state_d = (cnt_q == '0) ? ST_VAR : ST_DIVM;
      ST_DIVM: if (div_done) state_d = ST_DIVS;
      ST_DIVS: if (div_done) state_d = ST_MULM;
      ST_MULM: state_d = ST_VAR;
      ST_VAR:  state_d = ST_CONV;
      ST_CONV: state_d = ST_DEC;
      ST_DEC:  state_d = (again && !pass2_q) ? ST_PASS : ST_EMIT;
      ST_EMIT: if (emit_end) state_d = ST_LOAD;
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    pass_issue    = 1'b0;
    emit_issue    = 1'b0;
    div_start     = 1'b0;
    unique case (state_q)
      ST_LOAD: s_axis_tready = !out_v_q;
      ST_PASS: begin
        pass_issue = idx_q != n_q;
        div_start  = pass_end && (cnt_q != '0);
      end
      ST_DIVM: div_start = div_done;
      ST_EMIT: emit_issue = (idx_q != n_q) && !out_v_q && !pend_q;
      default: ;
    endcase
  end

  assign enter_pass = (state_d == ST_PASS) && (state_q != ST_PASS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      n_q     <= '0;
      idx_q   <= '0;
      pass2_q <= 1'b0;
      p1_q    <= 1'b0;
      p2_q    <= 1'b0;
      p3_q    <= 1'b0;
      pend_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      p1_q    <= pass_issue;
      p2_q    <= p1_q;
      p3_q    <= p2_q;
      pend_q  <= emit_issue;
      if (in_acc && (n_q != NW'(MAX_SAMPLES))) n_q <= n_q + 1'b1;
      if (state_q == ST_EMIT && emit_end) n_q <= '0;
      if (enter_pass || (state_d == ST_EMIT && state_q != ST_EMIT)) begin
        idx_q <= '0;
      end else if (pass_issue || emit_issue) begin
        idx_q <= idx_q + 1'b1;
      end
      if (enter_pass) pass2_q <= (state_q == ST_DEC);
      if (pend_q) out_v_q <= 1'b1;
      else if (out_acc) out_v_q <= 1'b0;
    end
  end

  // ---------------- sample memory ----------------
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = n_q[AW-1:0];
    wr_data = {s_axis_tuser, s_axis_tdata[31:0]};
    if (in_acc && (n_q != NW'(MAX_SAMPLES))) begin
      wr_en = 1'b1;
    end else if (p3_q) begin
      wr_en   = 1'b1;
      wr_addr = a3_q;
      wr_data = {mark3, smp3_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata_q <= mem[idx_q[AW-1:0]];
  end

  // ---------------- clip + gather pipeline ----------------
  assign smp1  = rdata_q[31:0];
  assign dev   = {smp1[31], smp1} - {hmean_q[31], hmean_q};
  assign hit   = (nine_q[67:64] == 4'd0) && (sqd_q > nine_q[63:0]);
  assign mark3 = mk3_q || hit;

  always_ff @(posedge clk_i) begin
    a1_q   <= idx_q[AW-1:0];
    a2_q   <= a1_q;
    a3_q   <= a2_q;
    ad_q   <= dev[32] ? 32'(-dev) : dev[31:0];
    as_q   <= smp1[31] ? -smp1 : smp1;
    smp2_q <= smp1;
    mk2_q  <= rdata_q[32];
    sqd_q  <= ad_q * ad_q;
    sqs_q  <= as_q * as_q;
    smp3_q <= smp2_q;
    mk3_q  <= mk2_q;
  end

  always_ff @(posedge clk_i) begin
    if (enter_pass) begin
      sum_q <= '0;
      sq_q  <= '0;
      cnt_q <= '0;
    end else if (p3_q && !mark3) begin
      sum_q <= sum_q + 40'(signed'(smp3_q));
      sq_q  <= sq_q + {6'd0, sqs_q[63:6]};
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // ---------------- statistics ----------------
  assign abs_sum  = sum_q[39] ? -sum_q : sum_q;
  assign dividend = (state_q == ST_PASS) ? {24'd0, abs_sum} : sq_q;

  scm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (CNT_W'(cnt_q)),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc && (n_q == '0)) begin
      hmean_q <= s_axis_tdata[63:32];
      hvar_q  <= s_axis_tdata[127:64];
      nine_q  <= {4'd0, s_axis_tdata[127:64]} + {1'b0, s_axis_tdata[127:64], 3'b000};
    end
    if (state_q == ST_DIVM && div_done) begin
      mag_q <= quot[31:0];
      neg_q <= sum_q[39];
    end
    if (state_q == ST_DIVS && div_done) e2_q <= {quot[57:0], 6'd0};
    if (state_q == ST_MULM) m2_q <= mag_q * mag_q;
    if (state_q == ST_VAR) begin
      if (cnt_q == '0) begin
        nv_q <= '0;
        nm_q <= '0;
      end else begin
        nv_q <= (e2_q > m2_q) ? e2_q - m2_q : 64'd0;
        nm_q <= neg_q ? -signed'(mag_q) : signed'(mag_q);
      end
    end
    if (state_q == ST_CONV) diff_q <= (nv_q > hvar_q) ? nv_q - hvar_q : hvar_q - nv_q;
    if (state_q == ST_DEC) begin
      hmean_q <= nm_q;
      hvar_q  <= nv_q;
      nine_q  <= {4'd0, nv_q} + {1'b0, nv_q, 3'b000};
    end
  end

  // ---------------- result output ----------------
  always_ff @(posedge clk_i) begin
    if (emit_issue) ea_q <= idx_q[AW-1:0];
    if (pend_q) begin
      o_idx_q  <= 6'(ea_q);
      o_excl_q <= rdata_q[32];
      if (NW'(ea_q) + 1'b1 == n_q) begin
        o_last_q <= 1'b1;
        o_mean_q <= hmean_q;
        o_var_q  <= hvar_q;
        o_kept_q <= 7'(cnt_q);
      end else begin
        o_last_q <= 1'b0;
        o_mean_q <= '0;
        o_var_q  <= '0;
        o_kept_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {3'd0, o_kept_q, o_var_q, o_mean_q, o_idx_q};
  assign m_axis_tuser  = o_excl_q;
  assign m_axis_tlast  = o_last_q;

  // ---------------- assertions ----------------
  a_out_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> state_q == ST_EMIT)
    else $error("result valid outside emit");

  a_kept_le_n: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DEC |-> cnt_q <= n_q)
    else $error("kept count above loaded count");

  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> state_q == ST_LOAD && !p3_q && !pend_q)
    else $error("sample taken while processing");

  a_stats_last_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[108:6] == '0)
    else $error("statistics on non-final result");

endmodule
`default_nettype wire

>>> hdl/scm_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle; 64-bit dividend, count-sized divisor.
module scm_div
  import scm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [63:0]       dividend_i,
  input  wire logic [CNT_W-1:0]  divisor_i,
  output logic                   done_o,
  output logic [63:0]            quot_o
);

  logic             busy_q;
  logic             done_q;
  logic [5:0]       step_q;
  logic [63:0]      dq_q;
  logic [CNT_W-1:0] rem_q;
  logic [CNT_W-1:0] div_q;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, dq_q[63]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 6'd1;
      if (step_q == 6'd63) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= {dq_q[62:0], ge};
      rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule
`default_nettype wire
